>>> hdl/cbd_pkg.sv
`timescale 1ns / 1ps

package cbd_pkg;

    localparam int POSITION_BITS = 32;
    localparam int POS_W         = POSITION_BITS;
    localparam int OUT_W         = 32;
    localparam int BYTE_BITS     = 8;
    localparam int RUN_SHIFT     = 10;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [15:0]      code_t;
    typedef logic [7:0]       dirty_t;
    typedef logic [OUT_W-1:0] out_pos_t;

    // one dirty byte waiting to be expanded into positions
    typedef struct packed {
        pos_t   base;
        dirty_t bits;
        logic   last;
    } cmd_t;

    // queue handshake between the classifier and the expander
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> hdl/cbd_ifs.sv
`timescale 1ns / 1ps

interface cbd_in_if;
    import cbd_pkg::*;

    logic  valid;
    logic  ready;
    code_t code_word;
    logic  last_word;

    modport source (output valid, output code_word, output last_word, input ready);
    modport sink   (input valid, input code_word, input last_word, output ready);
endinterface

interface cbd_out_if;
    import cbd_pkg::*;

    logic     valid;
    logic     ready;
    out_pos_t position;
    logic     last_of_word;
    logic     bitmap_end;

    modport source (output valid, output position, output last_of_word, output bitmap_end,
                    input ready);
    modport sink   (input valid, input position, input last_of_word, input bitmap_end,
                    output ready);
endinterface

>>> hdl/cbd_front.sv
`timescale 1ns / 1ps

module cbd_front (
    input  logic            clk,
    input  logic            rst_n,
    cbd_in_if.sink          din,
    input  cbd_pkg::q_stat_t q_stat,
    output logic            push,
    output cbd_pkg::cmd_t   cmd
);
    import cbd_pkg::*;

    pos_t   pos_base_reg;
    pos_t   pos_base_next;
    pos_t   skip_base;
    pos_t   run_adv;
    logic   is_run;
    logic   accept;
    dirty_t dirty;

    assign din.ready = !q_stat.full;
    assign accept    = din.valid && din.ready;
    assign is_run    = din.code_word[15];
    assign dirty     = din.code_word[7:0];

    assign skip_base = pos_base_reg + POS_W'({din.code_word[14:8], 3'b000});
    assign run_adv   = POS_W'({din.code_word[14:0], {RUN_SHIFT{1'b0}}});

    always_comb
    begin
        pos_base_next = pos_base_reg;
        if (accept)
        begin
            if (din.last_word)
                pos_base_next = '0;
            else if (is_run)
                pos_base_next = pos_base_reg + run_adv;
            else
                pos_base_next = skip_base + POS_W'(BYTE_BITS);
        end
    end

    assign push      = accept && !is_run && (dirty != '0);
    assign cmd.base  = skip_base;
    assign cmd.bits  = dirty;
    assign cmd.last  = din.last_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_base_reg <= '0;
        else
            pos_base_reg <= pos_base_next;
    end

endmodule

>>> hdl/cbd_queue.sv
`timescale 1ns / 1ps

module cbd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  cbd_pkg::q_ctrl_t q_ctrl,
    input  cbd_pkg::cmd_t    wr_cmd,
    output cbd_pkg::cmd_t    rd_cmd,
    output cbd_pkg::q_stat_t q_stat
);
    import cbd_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign q_stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = q_ctrl.push && !q_stat.full;
    assign do_pop       = q_ctrl.pop && !q_stat.empty;
    assign rd_cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

>>> hdl/cbd_back.sv
`timescale 1ns / 1ps

module cbd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  cbd_pkg::cmd_t    rd_cmd,
    input  cbd_pkg::q_stat_t q_stat,
    output logic             pop,
    cbd_out_if.source        dout
);
    import cbd_pkg::*;

    pos_t       cur_base_reg;
    pos_t       cur_base_next;
    dirty_t     cur_bits_reg;
    dirty_t     cur_bits_next;
    logic       cur_last_reg;
    logic       cur_last_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_pos_t   position_reg;
    out_pos_t   position_next;
    logic       last_of_word_reg;
    logic       last_of_word_next;
    logic       bitmap_end_reg;
    logic       bitmap_end_next;
    dirty_t     rem_bits;
    logic [2:0] bit_idx;
    logic       step;
    logic       done;

    assign step     = (cur_bits_reg != '0) && (!out_valid_reg || dout.ready);
    assign rem_bits = cur_bits_reg & (cur_bits_reg - 1'b1);
    assign done     = (cur_bits_reg == '0) || (step && (rem_bits == '0));
    assign pop      = done && !q_stat.empty;

    // lowest set bit first
    always_comb
    begin
        bit_idx = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (cur_bits_reg[i])
                bit_idx = 3'(i);
        end
    end

    always_comb
    begin
        cur_base_next     = cur_base_reg;
        cur_bits_next     = cur_bits_reg;
        cur_last_next     = cur_last_reg;
        out_valid_next    = out_valid_reg;
        position_next     = position_reg;
        last_of_word_next = last_of_word_reg;
        bitmap_end_next   = bitmap_end_reg;

        if (pop)
        begin
            cur_base_next = rd_cmd.base;
            cur_bits_next = rd_cmd.bits;
            cur_last_next = rd_cmd.last;
        end
        else if (step)
        begin
            cur_bits_next = rem_bits;
        end

        if (step)
        begin
            out_valid_next    = 1'b1;
            position_next     = OUT_W'(cur_base_reg + POS_W'(bit_idx));
            last_of_word_next = (rem_bits == '0);
            bitmap_end_next   = (rem_bits == '0) && cur_last_reg;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_bits_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_bits_reg  <= cur_bits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_base_reg     <= cur_base_next;
        cur_last_reg     <= cur_last_next;
        position_reg     <= position_next;
        last_of_word_reg <= last_of_word_next;
        bitmap_end_reg   <= bitmap_end_next;
    end

    assign dout.valid        = out_valid_reg;
    assign dout.position     = position_reg;
    assign dout.last_of_word = last_of_word_reg;
    assign dout.bitmap_end   = bitmap_end_reg;

endmodule

>>> hdl/compressed_bitmap_decoder.sv
`timescale 1ns / 1ps

// Decodes a stream of 16-bit compressed bitmap words into the bit index of
// every set bit. The front takes one word per cycle while its four-entry
// command queue has room; run words and dirty words with an empty byte only
// move the running position and are not queued. The back expands a queued
// dirty byte at one position per cycle through the output register while
// the output is not stalled, so the sustained rate is set by that expander.
// The first position of a word passes through the queue slot, the current
// byte register and the output register. A word marked last returns the
// running position to zero after it.
module compressed_bitmap_decoder (
    input  logic      clk,
    input  logic      rst_n,
    cbd_in_if.sink    din,
    cbd_out_if.source dout
);
    import cbd_pkg::*;

    cmd_t    wr_cmd;
    cmd_t    rd_cmd;
    q_ctrl_t q_ctrl;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    cbd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .din    (din),
        .q_stat (q_stat),
        .push   (push),
        .cmd    (wr_cmd)
    );

    cbd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_ctrl (q_ctrl),
        .wr_cmd (wr_cmd),
        .rd_cmd (rd_cmd),
        .q_stat (q_stat)
    );

    cbd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_cmd (rd_cmd),
        .q_stat (q_stat),
        .pop    (pop),
        .dout   (dout)
    );

endmodule

>>> hdl/cbd_checker.sv
`timescale 1ns / 1ps

module cbd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input cbd_pkg::out_pos_t    out_position,
    input logic                 out_last_of_word,
    input logic                 out_bitmap_end
);
    import cbd_pkg::*;

    // a stalled transaction keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_position)
            && $stable(out_last_of_word) && $stable(out_bitmap_end))
        else $error("output changed while stalled");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_bitmap_end |-> out_last_of_word)
        else $error("bitmap end without last of word");

    // the rest of a word follows without a gap
    a_word_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last_of_word |=> out_valid)
        else $error("gap inside a word");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind compressed_bitmap_decoder cbd_checker u_cbd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (dout.valid),
    .out_ready        (dout.ready),
    .out_position     (dout.position),
    .out_last_of_word (dout.last_of_word),
    .out_bitmap_end   (dout.bitmap_end)
);

>>> sim/compressed_bitmap_decoder_tb.sv
`timescale 1ns / 1ps

module compressed_bitmap_decoder_tb;
    import cbd_pkg::*;

    localparam int RUN_FLAG_BIT  = 15;
    localparam int RANDOM_WORDS  = 140;
    localparam int DRAIN_CYCLES  = 20;
    localparam int TIMEOUT_NS    = 3_000_000;

    typedef struct {
        out_pos_t position;
        logic     last_of_word;
        logic     bitmap_end;
    } bit_hit_t;

    class bitmap_scoreboard;
        bit_hit_t hits_due[$];
        pos_t     pos_base;
        int       errors;
        int       words_seen;
        int       runs_seen;
        int       bitmaps_seen;
        int       hits_checked;

        function new();
            pos_base     = '0;
            errors       = 0;
            words_seen   = 0;
            runs_seen    = 0;
            bitmaps_seen = 0;
            hits_checked = 0;
        endfunction

        function void note_word(input code_t c, input logic end_mark);
            pos_t     pos;
            bit_hit_t found[$];
            bit_hit_t h;
            pos = pos_base;
            words_seen++;
            if (c[RUN_FLAG_BIT])
            begin
                runs_seen++;
                pos = pos + (pos_t'(c[14:0]) << RUN_SHIFT);
            end
            else
            begin
                pos = pos + pos_t'(c[14:8]) * BYTE_BITS;
                for (int j = 0; j < 8; j++)
                begin
                    if (c[j])
                    begin
                        h.position     = out_pos_t'(pos + pos_t'(j));
                        h.last_of_word = 1'b0;
                        h.bitmap_end   = 1'b0;
                        found = {found, h};
                    end
                end
                pos = pos + pos_t'(BYTE_BITS);
                if (found.size() > 0)
                begin
                    found[found.size()-1].last_of_word = 1'b1;
                    found[found.size()-1].bitmap_end   = end_mark;
                end
                foreach (found[k])
                    hits_due = {hits_due, found[k]};
            end
            if (end_mark)
                bitmaps_seen++;
            pos_base = end_mark ? '0 : pos;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_hit(input out_pos_t p, input logic low, input logic bend);
            bit_hit_t h;
            hits_checked++;
            if (hits_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected position %08h", p));
            end
            else
            begin
                h = hits_due.pop_front();
                if (p !== h.position)
                    report_mismatch($sformatf("position %08h, want %08h", p, h.position));
                if (low !== h.last_of_word)
                    report_mismatch($sformatf("last_of_word %b, want %b at %08h",
                                              low, h.last_of_word, h.position));
                if (bend !== h.bitmap_end)
                    report_mismatch($sformatf("bitmap_end %b, want %b at %08h",
                                              bend, h.bitmap_end, h.position));
            end
        endtask

        function int pending();
            return hits_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    cbd_in_if  din ();
    cbd_out_if dout ();

    bitmap_scoreboard sb = new();

    compressed_bitmap_decoder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d positions outstanding", sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver side
    always @(negedge clk)
        dout.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && dout.valid && dout.ready)
            sb.check_hit(dout.position, dout.last_of_word, dout.bitmap_end);
    end

    // called at a falling edge, returns at a falling edge after the transaction
    task automatic send_word(input code_t c, input logic end_mark);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            din.valid     <= 1'b0;
            din.code_word <= code_t'($urandom_range(0, 65535));
            din.last_word <= 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        din.valid     <= 1'b1;
        din.code_word <= c;
        din.last_word <= end_mark;
        do
            @(posedge clk);
        while (!din.ready);
        sb.note_word(c, end_mark);
        @(negedge clk);
    endtask

    task automatic send_bitmap();
        int    n_words;
        code_t c;
        n_words = $urandom_range(1, 8);
        for (int i = 0; i < n_words; i++)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                c = 16'h8000;
                if ($urandom_range(0, 3) == 0)
                    c[14:0] = 15'($urandom_range(0, 32767));
                else
                    c[14:0] = 15'($urandom_range(0, 15));
            end
            else
            begin
                c = '0;
                if ($urandom_range(0, 1) == 0)
                    c[14:8] = 7'($urandom_range(0, 3));
                else
                    c[14:8] = 7'($urandom_range(0, 127));
                c[7:0] = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            end
            send_word(c, i == n_words - 1);
        end
    endtask

    initial
    begin
        code_t directed_codes[] = '{
            16'h0000, 16'h00FF, 16'h7F01, 16'h7F80, 16'h0080, 16'h8000, 16'hFFFF,
            16'h0101, 16'h00AA, 16'h0000, 16'h8001, 16'h0001, 16'h5A5A, 16'h2400,
            16'h00FF, 16'h7FFF, 16'hAAAA, 16'h0010, 16'h8000, 16'h0003
        };
        logic directed_ends[] = '{
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
            1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1
        };
        int sent_words;
        int phase;

        rst_n          = 1'b0;
        din.valid      = 1'b0;
        din.code_word  = '0;
        din.last_word  = 1'b0;
        dout.ready     = 1'b0;
        send_idle_pct  = 20;
        recv_idle_pct  = 71;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_codes[i])
            send_word(directed_codes[i], directed_ends[i]);

        sent_words = sb.words_seen;
        while (sb.words_seen - sent_words < RANDOM_WORDS)
        begin
            phase = ((sb.words_seen - sent_words) * 3) / RANDOM_WORDS;
            if (phase == 0)
            begin
                send_idle_pct = 20;
                recv_idle_pct = 71;
            end
            else if (phase == 1)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // mostly well-formed bitmaps, some loose words
            if ($urandom_range(0, 9) == 0)
                send_word(code_t'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            else
                send_bitmap();
        end

        din.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d words (%0d run words) in %0d bitmaps",
                 sb.words_seen, sb.runs_seen, sb.bitmaps_seen);
        $display("checked %0d positions under three handshake pacing phases",
                 sb.hits_checked);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/cbd_pkg.sv
hdl/cbd_ifs.sv
hdl/cbd_front.sv
hdl/cbd_queue.sv
hdl/cbd_back.sv
hdl/compressed_bitmap_decoder.sv
hdl/cbd_checker.sv
sim/compressed_bitmap_decoder_tb.sv
